/* hw/rtl/date_list_first_match_assert.svh */
// Assertion macros for the date list first-match block.
// Used by date_list_first_match.sv; expects clk and rst_n in scope.
`ifndef DATE_LIST_FIRST_MATCH_ASSERT_SVH
`define DATE_LIST_FIRST_MATCH_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define DLFM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define DLFM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/dlfm_pkg.sv */
// Shared types, constants and codes for the date list first-match block.
// No dependencies; used by dlfm_date_ok and date_list_first_match.
package dlfm_pkg;

  // Field widths
  localparam int DayW   = 6;
  localparam int MonthW = 4;
  localparam int YearW  = 16;
  localparam int IdxW   = 7;
  localparam int CritW  = 2;

  // Packed stream widths (whole bytes)
  localparam int InDataW  = 32;
  localparam int OutDataW = 8;

  // Configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  // Reach of match_index
  localparam int IndexReach = 128;
  localparam int DefListCapacity = 128;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegQueryDay   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegQueryMonth = 2'd1;
  localparam logic [CfgIdxW-1:0] RegQueryYear  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegCriterion  = 2'd3;

  // Register reset values
  localparam logic [DayW-1:0]   QueryDayRst   = 6'd1;
  localparam logic [MonthW-1:0] QueryMonthRst = 4'd1;
  localparam logic [YearW-1:0]  QueryYearRst  = 16'd1;

  // Criterion codes
  localparam logic [CritW-1:0] CritBefore = 2'b11;
  localparam logic [CritW-1:0] CritEqual  = 2'b00;
  localparam logic [CritW-1:0] CritAfter  = 2'b01;

  // Calendar constants
  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthApr = 4'd4;
  localparam logic [MonthW-1:0] MonthJun = 4'd6;
  localparam logic [MonthW-1:0] MonthSep = 4'd9;
  localparam logic [MonthW-1:0] MonthNov = 4'd11;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;
  localparam logic [DayW-1:0]   DaysFebLeap = 6'd29;
  localparam logic [DayW-1:0]   DaysFeb     = 6'd28;
  localparam logic [DayW-1:0]   DaysShort   = 6'd30;
  localparam logic [DayW-1:0]   DaysLong    = 6'd31;

  // Divisibility by 25: y * inv(25) mod 2^16 <= floor((2^16-1)/25).
  // Combined with the low bits this gives the 100 and 400 year rules.
  localparam logic [YearW-1:0] Inv25    = 16'd23593;
  localparam logic [YearW-1:0] Div25Max = 16'd2621;

  // Result of the date check, handed to the top level
  typedef struct packed {
    logic ok;
    logic leap;
  } date_chk_t;

endpackage

/* hw/rtl/dlfm_date_ok.sv */
// Gregorian date validity check (year, month, day range and leap rule).
// Depends on dlfm_pkg.
module dlfm_date_ok (
  input  logic [dlfm_pkg::DayW-1:0]   day,
  input  logic [dlfm_pkg::MonthW-1:0] month,
  input  logic [dlfm_pkg::YearW-1:0]  year,
  output dlfm_pkg::date_chk_t         chk
);

  logic [dlfm_pkg::YearW-1:0] prod;
  logic                       div25;
  logic                       leap;
  logic [dlfm_pkg::DayW-1:0]  last_day;

  // Multiply by the inverse of 25 mod 2^16; small result means divisible
  assign prod  = year * dlfm_pkg::Inv25;
  assign div25 = (prod <= dlfm_pkg::Div25Max);

  // Divisible by 4, and not by 100 unless by 400 (400 = 16 * 25)
  assign leap = (year[1:0] == 2'd0) && (!div25 || (year[3:0] == 4'd0));

  // Month length
  always_comb begin
    case (month)
      dlfm_pkg::MonthFeb: last_day = leap ? dlfm_pkg::DaysFebLeap : dlfm_pkg::DaysFeb;
      dlfm_pkg::MonthApr,
      dlfm_pkg::MonthJun,
      dlfm_pkg::MonthSep,
      dlfm_pkg::MonthNov: last_day = dlfm_pkg::DaysShort;
      default:            last_day = dlfm_pkg::DaysLong;
    endcase
  end

  assign chk.leap = leap;
  assign chk.ok   = (year != '0) &&
                    (month >= dlfm_pkg::MonthJan) && (month <= dlfm_pkg::MonthDec) &&
                    (day != '0) && (day <= last_day);

endmodule

/* hw/rtl/date_list_first_match.sv */
// A list date or end marker is registered in the input stage on accept; the result for an
// end marker then loads the output register, which drives out_tvalid.
// Throughput: one item per cycle; an end marker waits only while a previous result
// sits untaken in the output register, which is the single stall point.
// Reset (rst_n, synchronous, active low): search state cleared, query 1/1/1,
// criterion equal, both stages empty.
// Top level of the date list first-match block; depends on dlfm_pkg and dlfm_date_ok.
`include "date_list_first_match_assert.svh"
module date_list_first_match #(
  parameter int LIST_CAPACITY = dlfm_pkg::DefListCapacity
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dlfm_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [dlfm_pkg::CfgDataW-1:0] cfg_data,
  // Input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [dlfm_pkg::InDataW-1:0]  in_tdata,  // day[5:0], month[9:6], year[25:10], zero pad
  input  logic                          in_tlast,  // kind: end of list
  // Result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [dlfm_pkg::OutDataW-1:0] out_tdata, // match_index[6:0], zero pad
  output logic                          out_tuser  // found
);

  localparam int PosLimit = (LIST_CAPACITY < dlfm_pkg::IndexReach) ?
                            LIST_CAPACITY : dlfm_pkg::IndexReach;
  localparam int CntW     = $clog2(PosLimit + 1);

  // Query registers
  logic [dlfm_pkg::DayW-1:0]   q_day_r;
  logic [dlfm_pkg::MonthW-1:0] q_month_r;
  logic [dlfm_pkg::YearW-1:0]  q_year_r;
  logic [dlfm_pkg::CritW-1:0]  crit_r;

  // Input stage
  logic                        s1_valid_r;
  logic                        s1_last_r;
  logic [dlfm_pkg::DayW-1:0]   s1_day_r;
  logic [dlfm_pkg::MonthW-1:0] s1_month_r;
  logic [dlfm_pkg::YearW-1:0]  s1_year_r;

  // Search state
  logic [CntW-1:0]             count_r, count_nxt;
  logic                        hit_r, hit_nxt;
  logic [dlfm_pkg::IdxW-1:0]   hitpos_r, hitpos_nxt;

  // Result register
  logic                        out_valid_r;
  logic                        out_found_r;
  logic [dlfm_pkg::IdxW-1:0]   out_index_r;

  logic                        out_free;
  logic                        s1_go;
  logic                        in_take;
  dlfm_pkg::date_chk_t         item_chk;
  logic [dlfm_pkg::YearW+dlfm_pkg::MonthW+dlfm_pkg::DayW-1:0] item_key, query_key;
  dlfm_pkg::date_chk_t         query_chk;
  logic                        is_match;

  assign cfg_ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_day_r   <= dlfm_pkg::QueryDayRst;
      q_month_r <= dlfm_pkg::QueryMonthRst;
      q_year_r  <= dlfm_pkg::QueryYearRst;
      crit_r    <= dlfm_pkg::CritEqual;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dlfm_pkg::RegQueryDay:   q_day_r   <= cfg_data[dlfm_pkg::DayW-1:0];
        dlfm_pkg::RegQueryMonth: q_month_r <= cfg_data[dlfm_pkg::MonthW-1:0];
        dlfm_pkg::RegQueryYear:  q_year_r  <= cfg_data[dlfm_pkg::YearW-1:0];
        dlfm_pkg::RegCriterion:  crit_r    <= cfg_data[dlfm_pkg::CritW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: end marker advances only into a free result register
  assign out_free  = !out_valid_r || out_tready;
  assign s1_go     = s1_valid_r && (!s1_last_r || out_free);
  assign in_tready = !s1_valid_r || s1_go;
  assign in_take   = in_tvalid && in_tready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_last_r  <= in_tlast;
      s1_day_r   <= in_tdata[5:0];
      s1_month_r <= in_tdata[9:6];
      s1_year_r  <= in_tdata[25:10];
    end
  end

  // Validity of list date and query
  dlfm_date_ok u_item_ok (
    .day   (s1_day_r),
    .month (s1_month_r),
    .year  (s1_year_r),
    .chk   (item_chk)
  );

  dlfm_date_ok u_query_ok (
    .day   (q_day_r),
    .month (q_month_r),
    .year  (q_year_r),
    .chk   (query_chk)
  );

  // Valid dates compare as one key: year, then month, then day
  assign item_key  = {s1_year_r, s1_month_r, s1_day_r};
  assign query_key = {q_year_r, q_month_r, q_day_r};

  always_comb begin
    case (crit_r)
      dlfm_pkg::CritBefore: is_match = item_key < query_key;
      dlfm_pkg::CritEqual:  is_match = item_key == query_key;
      dlfm_pkg::CritAfter:  is_match = item_key > query_key;
      default:              is_match = 1'b0;
    endcase
    is_match = is_match && item_chk.ok && query_chk.ok;
  end

  // Search state update
  always_comb begin
    count_nxt  = count_r;
    hit_nxt    = hit_r;
    hitpos_nxt = hitpos_r;
    if (s1_go) begin
      if (s1_last_r) begin
        count_nxt  = '0;
        hit_nxt    = 1'b0;
        hitpos_nxt = '0;
      end else if (count_r < CntW'(PosLimit)) begin
        if (!hit_r && is_match) begin
          hit_nxt    = 1'b1;
          hitpos_nxt = dlfm_pkg::IdxW'(count_r);
        end
        count_nxt = count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      hit_r    <= 1'b0;
      hitpos_r <= '0;
    end else begin
      count_r  <= count_nxt;
      hit_r    <= hit_nxt;
      hitpos_r <= hitpos_nxt;
    end
  end

  // Result register: load on end marker, drop on transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last_r) begin
      out_found_r <= hit_r;
      out_index_r <= hit_r ? hitpos_r : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = {1'b0, out_index_r};

  // Checks
  `DLFM_ASSERT_NOW(a_notfound_zero, out_tvalid && !out_tuser, out_tdata == '0,
                   "not-found result carries nonzero index")
  `DLFM_ASSERT_NOW(a_hit_counted, hit_r, (count_r != '0) && (CntW'(hitpos_r) < count_r),
                   "hit position not below item count")
  `DLFM_ASSERT_NOW(a_count_limit, 1'b1, count_r <= CntW'(PosLimit), "item count beyond limit")
  `DLFM_ASSERT_NEXT(a_end_clears, s1_go && s1_last_r, (count_r == '0) && !hit_r && out_valid_r,
                    "end marker did not clear search state")

endmodule
